// File: hw/rtl/mcg_pkg.sv
// Package for the metronome click generator.
// Holds item types, codes, widths and reset values for the divider and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package mcg_pkg;

    localparam int WAVE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(WAVE_DEPTH);
    localparam int POS1_W     = ADDR_W + 1;
    localparam int LEN_W      = 13;

    localparam int PROD_W = 37;
    localparam int DIVD_W = 35;
    localparam int DIVS_W = 16;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 20;

    localparam logic [CFG_AW-1:0] CFG_FRAMES_PER_BEAT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ATTACK_FRAMES   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DECAY_FRAMES    = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_WAVE_LENGTH     = 2'd3;

    localparam logic [19:0] RST_FRAMES_PER_BEAT = 20'd24000;
    localparam logic [15:0] RST_ATTACK_FRAMES   = 16'd240;
    localparam logic [15:0] RST_DECAY_FRAMES    = 16'd3600;
    localparam logic [8:0]  RST_WAVE_LENGTH     = 9'd54;

    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_TRANSPORT = 2'd1;
    localparam logic [1:0] ACT_TABLE_WR  = 2'd2;

    localparam logic [1:0] PH_ATTACK = 2'd0;
    localparam logic [1:0] PH_DECAY  = 2'd1;
    localparam logic [1:0] PH_OFF    = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic               running;
        logic               beat_valid;
        logic [15:0]        beat_fraction;
        logic [7:0]         table_index;
        logic signed [15:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         envelope_phase;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SYNC = 7'b0000010,
        S_READ = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MODW = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

// File: hw/rtl/mcg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses the request and response types of mcg_pkg.
`timescale 1ns / 1ps

module mcg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcg_pkg::t_div_req i_req,
    output mcg_pkg::t_div_rsp o_rsp
);

    logic [mcg_pkg::DIVD_W-1:0] r_quo;
    logic [mcg_pkg::DIVS_W-1:0] r_rem;
    logic [mcg_pkg::DIVS_W-1:0] r_dvs;
    logic [mcg_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_done;

    logic                       w_busy;
    logic [mcg_pkg::DIVS_W:0]   w_trial;
    logic [mcg_pkg::DIVS_W:0]   w_diff;
    logic                       w_ge;

    assign w_busy  = (r_cnt != '0);
    assign w_trial = {r_rem, r_quo[mcg_pkg::DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_busy && (r_cnt == mcg_pkg::CNT_W'(1));
            if (w_busy) begin
                r_cnt <= r_cnt - mcg_pkg::CNT_W'(1);
            end else if (i_req.start) begin
                r_cnt <= mcg_pkg::CNT_W'(mcg_pkg::DIVD_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_busy) begin
            r_rem <= w_ge ? w_diff[mcg_pkg::DIVS_W-1:0] : w_trial[mcg_pkg::DIVS_W-1:0];
            r_quo <= {r_quo[mcg_pkg::DIVD_W-2:0], w_ge};
        end else if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.busy      = w_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// File: hw/rtl/metronome_click_generator.sv
// Metronome click generator top level: sequencer, wavetable, shared multiplier and output register.
// Depends on mcg_pkg and mcg_div.
// A running tick in attack or decay passes through S_READ, S_MUL, the 35-step divider
// in S_DIV and S_DONE; in the off phase it skips the sample division.
// A tick after a wave length change that leaves the position past the end also waits in S_MODW.
// Stopped ticks go to S_DONE, beat syncs to S_SYNC, table writes stay idle; one item at a time.
// Synchronous active-low reset restores control registers; datapath regs and wavetable are kept.
`timescale 1ns / 1ps

module metronome_click_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mcg_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [mcg_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mcg_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mcg_pkg::t_out_item         o_out_item
);

    mcg_pkg::t_state r_state, n_state;
    logic [19:0] r_fpb, n_fpb;
    logic [15:0] r_atk, n_atk;
    logic [15:0] r_dec, n_dec;
    logic [8:0]  r_wlen, n_wlen;
    logic [19:0] r_bc, n_bc;
    logic [mcg_pkg::ADDR_W-1:0] r_wpos, n_wpos;
    logic [1:0]  r_env, n_env;
    logic        r_run, n_run;
    mcg_pkg::t_in_item r_in, n_in;
    logic        r_neg, n_neg;
    logic [1:0]  r_ph, n_ph;
    logic signed [15:0] r_res, n_res;
    logic [mcg_pkg::POS1_W-1:0] r_pos1, n_pos1;
    logic        r_need_mod, n_need_mod;
    logic        r_out_valid, n_out_valid;
    mcg_pkg::t_out_item r_out, n_out;

    logic signed [15:0] r_mem [mcg_pkg::WAVE_DEPTH];
    logic signed [15:0] r_w;

    logic               w_accept;
    logic               w_mem_we;
    logic [mcg_pkg::LEN_W-1:0] w_tidx;
    logic [15:0]        w_a_eff;
    logic [15:0]        w_d_eff;
    logic [16:0]        w_ad;
    logic signed [20:0] w_rem;
    logic signed [20:0] w_rem_neg;
    logic [19:0]        w_rem_abs;
    logic signed [16:0] w_w_ext;
    logic signed [16:0] w_w_neg;
    logic [16:0]        w_w_abs;
    logic [16:0]        w_mul_a;
    logic [19:0]        w_mul_b;
    logic [mcg_pkg::PROD_W-1:0] w_prod;
    logic [19:0]        w_sync_bc;
    logic [mcg_pkg::LEN_W-1:0] w_len;
    logic [mcg_pkg::POS1_W-1:0] w_pos1;
    logic [mcg_pkg::LEN_W-1:0] w_pos1_ext;
    logic [19:0]        w_bc_inc;
    logic [1:0]         w_ph_used;
    logic [mcg_pkg::DIVD_W-1:0] w_q;
    logic [mcg_pkg::DIVD_W-1:0] w_q_neg;
    logic signed [15:0] w_sat;

    mcg_pkg::t_div_req w_div_req;
    mcg_pkg::t_div_rsp w_div_rsp;

    mcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready  = (r_state == mcg_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_tidx   = mcg_pkg::LEN_W'(i_in_item.table_index);
    assign w_mem_we = w_accept && (i_in_item.action == mcg_pkg::ACT_TABLE_WR)
                      && (w_tidx < mcg_pkg::LEN_W'(mcg_pkg::WAVE_DEPTH));

    assign w_a_eff   = (r_atk == '0) ? 16'd1 : r_atk;
    assign w_d_eff   = (r_dec == '0) ? 16'd1 : r_dec;
    assign w_ad      = 17'(r_atk) + 17'(r_dec);
    assign w_rem     = $signed({4'b0000, w_ad}) - $signed({1'b0, r_bc});
    assign w_rem_neg = -w_rem;
    assign w_rem_abs = w_rem[20] ? w_rem_neg[19:0] : w_rem[19:0];
    assign w_w_ext   = {r_w[15], r_w};
    assign w_w_neg   = -w_w_ext;
    assign w_w_abs   = r_w[15] ? w_w_neg : w_w_ext;

    always_comb begin
        if (r_state == mcg_pkg::S_SYNC) begin
            w_mul_a = 17'(r_in.beat_fraction);
            w_mul_b = r_fpb;
        end else begin
            w_mul_a = w_w_abs;
            w_mul_b = (r_env == mcg_pkg::PH_DECAY) ? w_rem_abs : r_bc;
        end
    end

    assign w_prod    = mcg_pkg::PROD_W'(w_mul_a) * mcg_pkg::PROD_W'(w_mul_b);
    assign w_sync_bc = w_prod[35:16];

    always_comb begin
        if (r_wlen == '0) begin
            w_len = mcg_pkg::LEN_W'(1);
        end else if (mcg_pkg::LEN_W'(r_wlen) > mcg_pkg::LEN_W'(mcg_pkg::WAVE_DEPTH)) begin
            w_len = mcg_pkg::LEN_W'(mcg_pkg::WAVE_DEPTH);
        end else begin
            w_len = mcg_pkg::LEN_W'(r_wlen);
        end
    end

    assign w_pos1     = {1'b0, r_wpos} + mcg_pkg::POS1_W'(1);
    assign w_pos1_ext = mcg_pkg::LEN_W'(w_pos1);
    assign w_bc_inc   = r_bc + 20'd1;
    assign w_ph_used  = (r_env == mcg_pkg::PH_ATTACK || r_env == mcg_pkg::PH_DECAY)
                        ? r_env : mcg_pkg::PH_OFF;

    assign w_q     = w_div_rsp.quotient;
    assign w_q_neg = ~w_q + mcg_pkg::DIVD_W'(1);

    always_comb begin
        if (r_neg) begin
            w_sat = (w_q > mcg_pkg::DIVD_W'(32768)) ? 16'sh8000 : $signed(w_q_neg[15:0]);
        end else begin
            w_sat = (w_q > mcg_pkg::DIVD_W'(32767)) ? 16'sh7fff : $signed(w_q[15:0]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fpb       = r_fpb;
        n_atk       = r_atk;
        n_dec       = r_dec;
        n_wlen      = r_wlen;
        n_bc        = r_bc;
        n_wpos      = r_wpos;
        n_env       = r_env;
        n_run       = r_run;
        n_in        = r_in;
        n_neg       = r_neg;
        n_ph        = r_ph;
        n_res       = r_res;
        n_pos1      = r_pos1;
        n_need_mod  = r_need_mod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = mcg_pkg::DIVD_W'(r_pos1);
        w_div_req.divisor  = mcg_pkg::DIVS_W'(w_len);

        if (i_cfg_we) begin
            case (i_cfg_addr)
                mcg_pkg::CFG_FRAMES_PER_BEAT: n_fpb  = i_cfg_wdata;
                mcg_pkg::CFG_ATTACK_FRAMES:   n_atk  = i_cfg_wdata[15:0];
                mcg_pkg::CFG_DECAY_FRAMES:    n_dec  = i_cfg_wdata[15:0];
                mcg_pkg::CFG_WAVE_LENGTH:     n_wlen = i_cfg_wdata[8:0];
                default: ;
            endcase
        end

        case (r_state)
            mcg_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_in = i_in_item;
                    case (i_in_item.action)
                        mcg_pkg::ACT_TICK: begin
                            if (r_run) begin
                                n_state = mcg_pkg::S_READ;
                            end else begin
                                n_res   = 16'sd0;
                                n_ph    = mcg_pkg::PH_OFF;
                                n_state = mcg_pkg::S_DONE;
                            end
                        end
                        mcg_pkg::ACT_TRANSPORT: begin
                            n_run = i_in_item.running;
                            if (i_in_item.beat_valid) begin
                                n_state = mcg_pkg::S_SYNC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mcg_pkg::S_SYNC: begin
                n_bc = w_sync_bc;
                if (w_sync_bc < 20'(r_atk)) begin
                    n_env = mcg_pkg::PH_ATTACK;
                end else if (w_sync_bc < 20'(w_ad)) begin
                    n_env = mcg_pkg::PH_DECAY;
                end else begin
                    n_env = mcg_pkg::PH_OFF;
                end
                n_state = mcg_pkg::S_IDLE;
            end
            mcg_pkg::S_READ: begin
                n_state = mcg_pkg::S_MUL;
            end
            mcg_pkg::S_MUL: begin
                n_ph  = w_ph_used;
                n_neg = r_w[15] ^ ((w_ph_used == mcg_pkg::PH_DECAY) && w_rem[20]);
                if (w_ph_used == mcg_pkg::PH_ATTACK && r_bc >= 20'(r_atk)) begin
                    n_env = mcg_pkg::PH_DECAY;
                end
                if (w_ph_used == mcg_pkg::PH_DECAY && r_bc >= 20'(w_ad)) begin
                    n_env = mcg_pkg::PH_OFF;
                end
                n_bc = w_bc_inc;
                if (w_bc_inc >= r_fpb) begin
                    n_bc  = '0;
                    n_env = mcg_pkg::PH_ATTACK;
                end
                n_pos1     = w_pos1;
                n_need_mod = 1'b0;
                if (w_pos1_ext < w_len) begin
                    n_wpos = w_pos1[mcg_pkg::ADDR_W-1:0];
                end else if (w_pos1_ext == w_len) begin
                    n_wpos = '0;
                end else begin
                    n_need_mod = 1'b1;
                end
                if (w_ph_used == mcg_pkg::PH_OFF) begin
                    n_res = 16'sd0;
                    if (n_need_mod) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = mcg_pkg::DIVD_W'(w_pos1);
                        n_state            = mcg_pkg::S_MODW;
                    end else begin
                        n_state = mcg_pkg::S_DONE;
                    end
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_prod[mcg_pkg::DIVD_W-1:0];
                    w_div_req.divisor  = (w_ph_used == mcg_pkg::PH_ATTACK) ? w_a_eff : w_d_eff;
                    n_state            = mcg_pkg::S_DIV;
                end
            end
            mcg_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res = w_sat;
                    if (r_need_mod) begin
                        w_div_req.start = 1'b1;
                        n_state         = mcg_pkg::S_MODW;
                    end else begin
                        n_state = mcg_pkg::S_DONE;
                    end
                end
            end
            mcg_pkg::S_MODW: begin
                if (w_div_rsp.done) begin
                    n_wpos  = w_div_rsp.remainder[mcg_pkg::ADDR_W-1:0];
                    n_state = mcg_pkg::S_DONE;
                end
            end
            mcg_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.sample         = r_res;
                    n_out.envelope_phase = r_ph;
                    n_state              = mcg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcg_pkg::S_IDLE;
            r_fpb       <= mcg_pkg::RST_FRAMES_PER_BEAT;
            r_atk       <= mcg_pkg::RST_ATTACK_FRAMES;
            r_dec       <= mcg_pkg::RST_DECAY_FRAMES;
            r_wlen      <= mcg_pkg::RST_WAVE_LENGTH;
            r_bc        <= '0;
            r_wpos      <= '0;
            r_env       <= mcg_pkg::PH_OFF;
            r_run       <= 1'b0;
            r_need_mod  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fpb       <= n_fpb;
            r_atk       <= n_atk;
            r_dec       <= n_dec;
            r_wlen      <= n_wlen;
            r_bc        <= n_bc;
            r_wpos      <= n_wpos;
            r_env       <= n_env;
            r_run       <= n_run;
            r_need_mod  <= n_need_mod;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_neg  <= n_neg;
        r_ph   <= n_ph;
        r_res  <= n_res;
        r_pos1 <= n_pos1;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_tidx[mcg_pkg::ADDR_W-1:0]] <= i_in_item.table_value;
        end
        if (r_state == mcg_pkg::S_READ) begin
            r_w <= r_mem[r_wpos];
        end
    end

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcg_pkg::S_DIV || r_state == mcg_pkg::S_MODW)
            |-> (w_div_rsp.busy || w_div_rsp.done))
        else $error("divider idle while the sequencer waits on it");

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_rsp.busy)
        else $error("divider busy while the block takes a new item");

    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.envelope_phase == mcg_pkg::PH_OFF) |-> (r_out.sample == 16'sd0))
        else $error("off phase item carries a nonzero sample");

    a_env_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env != 2'd3)
        else $error("envelope state holds an unused code");

endmodule
